// File: rtl/sorted_table_binary_search_assert.svh
// Assertion macros shared by the checker of the sorted table search block.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef SORTED_TABLE_BINARY_SEARCH_ASSERT_SVH
`define SORTED_TABLE_BINARY_SEARCH_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define STBS_ASSERT_SAME(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define STBS_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: rtl/stbs_pkg.sv
// Shared types and constants for the sorted table search block.
// Used by every module of the block; depends on nothing.
package stbs_pkg;

    localparam int DEPTH     = 1024;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int COUNT_W   = ADDR_W + 1;
    localparam int KEY_W     = 32;
    localparam int VALUE_W   = 32;
    localparam int CNT_W     = 32;
    localparam int S_TDATA_W = 64;
    localparam int M_DATA_BITS = VALUE_W + COUNT_W + 2 * CNT_W;
    localparam int M_TDATA_W = ((M_DATA_BITS + 7) / 8) * 8;
    localparam int M_PAD_W   = M_TDATA_W - M_DATA_BITS;

    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_SEARCH = 1'b1;

    localparam logic [1:0] COST_EQ = 2'd1;
    localparam logic [1:0] COST_GT = 2'd2;
    localparam logic [1:0] COST_LT = 2'd3;

    typedef enum logic [1:0] {
        REL_EQ = 2'b00,
        REL_GT = 2'b01,
        REL_LT = 2'b10
    } rel_t;

    typedef struct packed {
        logic               en;
        logic [ADDR_W-1:0]  addr;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
    } wr_req_t;

    // Midpoint of the half-open range [lo, hi_end), rounded down.
    function automatic logic [ADDR_W-1:0] mid_of(input logic [COUNT_W-1:0] lo,
                                                 input logic [COUNT_W-1:0] hi_end);
        logic [COUNT_W:0] sum;
        sum = {1'b0, lo} + {1'b0, hi_end} - {{COUNT_W{1'b0}}, 1'b1};
        return sum[ADDR_W:1];
    endfunction

endpackage

// File: rtl/stbs_table.sv
// Key and value storage of the sorted table, one write and one read port.
// Depends on stbs_pkg; read data is registered and holds between reads.
module stbs_table (
    input  logic                         aclk,
    input  stbs_pkg::wr_req_t            wr_req,
    input  logic                         rd_en,
    input  logic [stbs_pkg::ADDR_W-1:0]  rd_addr,
    output logic [stbs_pkg::KEY_W-1:0]   rd_key,
    output logic [stbs_pkg::VALUE_W-1:0] rd_value
);

    logic [stbs_pkg::KEY_W-1:0]   key_mem   [stbs_pkg::DEPTH];
    logic [stbs_pkg::VALUE_W-1:0] value_mem [stbs_pkg::DEPTH];
    logic [stbs_pkg::KEY_W-1:0]   rd_key_reg;
    logic [stbs_pkg::VALUE_W-1:0] rd_value_reg;

    always_ff @(posedge aclk) begin
        if (wr_req.en) begin
            key_mem[wr_req.addr]   <= wr_req.key;
            value_mem[wr_req.addr] <= wr_req.value;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_key_reg   <= key_mem[rd_addr];
            rd_value_reg <= value_mem[rd_addr];
        end
    end

    assign rd_key   = rd_key_reg;
    assign rd_value = rd_value_reg;

endmodule

// File: rtl/stbs_cmp.sv
// Three-way key comparator shared by every probe of a search.
// Depends on stbs_pkg; signed mode flips the sign bits before comparing.
module stbs_cmp (
    input  logic [stbs_pkg::KEY_W-1:0] entry_key,
    input  logic [stbs_pkg::KEY_W-1:0] search_key,
    input  logic                       compare_signed,
    output stbs_pkg::rel_t             rel
);

    logic [stbs_pkg::KEY_W-1:0] flip;
    logic [stbs_pkg::KEY_W-1:0] entry_adj;
    logic [stbs_pkg::KEY_W-1:0] search_adj;

    assign flip       = {compare_signed, {(stbs_pkg::KEY_W-1){1'b0}}};
    assign entry_adj  = entry_key ^ flip;
    assign search_adj = search_key ^ flip;

    always_comb begin
        if (entry_adj == search_adj) begin
            rel = stbs_pkg::REL_EQ;
        end else if (entry_adj > search_adj) begin
            rel = stbs_pkg::REL_GT;
        end else begin
            rel = stbs_pkg::REL_LT;
        end
    end

endmodule

// File: rtl/sorted_table_binary_search.sv
// Channel | Ports                    | Beat contents (low bits first)
// input   | s_tvalid/s_tready/s_tdata | tuser: func; tdata: entry_key, entry_value
// result  | m_tvalid/m_tready/m_tdata | tuser: found, table_full_error;
//         |                          | tdata: found_value, fill_level, search_total,
//         |                          |        compare_cost_total, zero pad
// A load goes through ST_DONE to the result register. A search first makes
// its probes (at most 11 for 1024 entries), one probe per cycle through the
// table read port and the shared comparator.
// Reset is synchronous and active low; it empties the table and clears counts.
// The input is not ready while an item is in progress or its result is blocked.
module sorted_table_binary_search (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic                           cfg_wr_data,  // compare_signed
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [stbs_pkg::S_TDATA_W-1:0] s_tdata,      // entry_key, entry_value
    input  logic                           s_tuser,      // func
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // found_value, fill_level, search_total, compare_cost_total, zero pad
    output logic [stbs_pkg::M_TDATA_W-1:0] m_tdata,
    output logic [1:0]                     m_tuser       // found, table_full_error
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_PROBE = 3'b010,
        ST_DONE  = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic                           signed_reg;
    logic [stbs_pkg::COUNT_W-1:0]   count_reg, count_next;
    logic [stbs_pkg::CNT_W-1:0]     search_cnt_reg, search_cnt_next;
    logic [stbs_pkg::CNT_W-1:0]     cost_cnt_reg, cost_cnt_next;
    logic                           m_valid_reg, m_valid_next;

    logic [stbs_pkg::COUNT_W-1:0]   lo_reg, lo_next;
    logic [stbs_pkg::COUNT_W-1:0]   end_reg, end_next;
    logic [stbs_pkg::ADDR_W-1:0]    mid_reg, mid_next;
    logic [stbs_pkg::KEY_W-1:0]     key_reg, key_next;
    logic                           found_reg, found_next;
    logic [stbs_pkg::VALUE_W-1:0]   hit_value_reg, hit_value_next;
    logic                           full_err_reg, full_err_next;
    logic [stbs_pkg::M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [1:0]                     m_tuser_reg, m_tuser_next;

    logic                           accept;
    logic                           table_full;
    logic [stbs_pkg::KEY_W-1:0]     in_key;
    logic [stbs_pkg::VALUE_W-1:0]   in_value;
    logic [stbs_pkg::COUNT_W-1:0]   probe_lo;
    logic [stbs_pkg::COUNT_W-1:0]   probe_end;
    logic [1:0]                     probe_cost;
    logic                           rd_en;
    logic [stbs_pkg::ADDR_W-1:0]    rd_addr;
    logic [stbs_pkg::KEY_W-1:0]     rd_key;
    logic [stbs_pkg::VALUE_W-1:0]   rd_value;
    stbs_pkg::wr_req_t              wr_req;
    stbs_pkg::rel_t                 rel;

    assign accept     = s_tvalid && s_tready;
    assign s_tready   = (state_reg == ST_IDLE);
    assign in_key     = s_tdata[stbs_pkg::KEY_W-1:0];
    assign in_value   = s_tdata[stbs_pkg::KEY_W +: stbs_pkg::VALUE_W];
    assign table_full = (count_reg == stbs_pkg::COUNT_W'(stbs_pkg::DEPTH));

    stbs_table u_table (
        .aclk     (aclk),
        .wr_req   (wr_req),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_key   (rd_key),
        .rd_value (rd_value)
    );

    stbs_cmp u_cmp (
        .entry_key      (rd_key),
        .search_key     (key_reg),
        .compare_signed (signed_reg),
        .rel            (rel)
    );

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        search_cnt_next = search_cnt_reg;
        cost_cnt_next   = cost_cnt_reg;
        m_valid_next    = m_valid_reg;
        lo_next         = lo_reg;
        end_next        = end_reg;
        mid_next        = mid_reg;
        key_next        = key_reg;
        found_next      = found_reg;
        hit_value_next  = hit_value_reg;
        full_err_next   = full_err_reg;
        m_tdata_next    = m_tdata_reg;
        m_tuser_next    = m_tuser_reg;
        wr_req.en       = 1'b0;
        wr_req.addr     = count_reg[stbs_pkg::ADDR_W-1:0];
        wr_req.key      = in_key;
        wr_req.value    = in_value;
        rd_en           = 1'b0;
        rd_addr         = stbs_pkg::mid_of(lo_reg, end_reg);
        probe_lo        = lo_reg;
        probe_end       = end_reg;
        probe_cost      = stbs_pkg::COST_LT;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    found_next     = 1'b0;
                    hit_value_next = '0;
                    full_err_next  = 1'b0;
                    if (s_tuser == stbs_pkg::FUNC_LOAD) begin
                        if (table_full) begin
                            full_err_next = 1'b1;
                        end else begin
                            wr_req.en  = 1'b1;
                            count_next = count_reg + 1'b1;
                        end
                        state_next = ST_DONE;
                    end else begin
                        search_cnt_next = search_cnt_reg + 1'b1;
                        key_next        = in_key;
                        lo_next         = '0;
                        end_next        = count_reg;
                        if (count_reg != '0) begin
                            rd_en      = 1'b1;
                            rd_addr    = stbs_pkg::mid_of('0, count_reg);
                            mid_next   = rd_addr;
                            state_next = ST_PROBE;
                        end else begin
                            state_next = ST_DONE;
                        end
                    end
                end
            end
            ST_PROBE: begin
                case (rel)
                    stbs_pkg::REL_EQ: begin
                        probe_cost = stbs_pkg::COST_EQ;
                    end
                    stbs_pkg::REL_GT: begin
                        probe_cost = stbs_pkg::COST_GT;
                        probe_end  = {1'b0, mid_reg};
                    end
                    default: begin
                        probe_cost = stbs_pkg::COST_LT;
                        probe_lo   = {1'b0, mid_reg} + 1'b1;
                    end
                endcase
                cost_cnt_next = cost_cnt_reg + stbs_pkg::CNT_W'(probe_cost);
                lo_next       = probe_lo;
                end_next      = probe_end;
                if (rel == stbs_pkg::REL_EQ) begin
                    found_next     = 1'b1;
                    hit_value_next = rd_value;
                    state_next     = ST_DONE;
                end else if (probe_lo < probe_end) begin
                    rd_en    = 1'b1;
                    rd_addr  = stbs_pkg::mid_of(probe_lo, probe_end);
                    mid_next = rd_addr;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_tdata_next = {{stbs_pkg::M_PAD_W{1'b0}}, cost_cnt_reg, search_cnt_reg,
                                    count_reg, hit_value_reg};
                    m_tuser_next = {full_err_reg, found_reg};
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            signed_reg     <= 1'b0;
            count_reg      <= '0;
            search_cnt_reg <= '0;
            cost_cnt_reg   <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            search_cnt_reg <= search_cnt_next;
            cost_cnt_reg   <= cost_cnt_next;
            m_valid_reg    <= m_valid_next;
            if (cfg_wr_en) begin
                signed_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        lo_reg        <= lo_next;
        end_reg       <= end_next;
        mid_reg       <= mid_next;
        key_reg       <= key_next;
        found_reg     <= found_next;
        hit_value_reg <= hit_value_next;
        full_err_reg  <= full_err_next;
        m_tdata_reg   <= m_tdata_next;
        m_tuser_reg   <= m_tuser_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// File: rtl/stbs_checker.sv
// Port-level checker for the sorted table search block, bound to the top level.
// Depends on stbs_pkg and sorted_table_binary_search_assert.svh.
`include "sorted_table_binary_search_assert.svh"

module stbs_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [stbs_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [1:0]                     m_tuser
);

    // A stalled result beat keeps its contents.
    `STBS_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // The block is not ready in the cycle after it accepts an item.
    `STBS_ASSERT_NEXT(a_busy_after_beat, aclk, aresetn, s_tvalid && s_tready, !s_tready)

    // A hit and a dropped load never share a result beat.
    `STBS_ASSERT_SAME(a_hit_not_error, aclk, aresetn, m_tvalid, !(m_tuser[0] && m_tuser[1]))

    // A miss reports a zero value and the fill level stays within the table.
    `STBS_ASSERT_SAME(a_miss_zero, aclk, aresetn, m_tvalid && !m_tuser[0],
        (m_tdata[stbs_pkg::VALUE_W-1:0] == '0) &&
        (m_tdata[stbs_pkg::VALUE_W +: stbs_pkg::COUNT_W] <=
         stbs_pkg::COUNT_W'(stbs_pkg::DEPTH)))

endmodule

bind sorted_table_binary_search stbs_checker u_stbs_checker (.*);

// File: sim/sorted_table_binary_search_tb.sv
`timescale 1ns / 1ps
// Testbench for sorted_table_binary_search: streams load and search beats, predicts every reply
// with its own copy of the table and counters, and checks the replies in order.
// Depends on stbs_pkg and the sorted_table_binary_search RTL only.
module sorted_table_binary_search_tb;

    localparam int CYCLE_LIMIT = 500000;

    typedef struct packed {
        logic                         found;
        logic [stbs_pkg::VALUE_W-1:0] value;
        logic [stbs_pkg::COUNT_W-1:0] fill;
        logic                         full_err;
        logic [stbs_pkg::CNT_W-1:0]   searches;
        logic [stbs_pkg::CNT_W-1:0]   cost;
    } lookup_reply_t;

    logic                             aclk = 1'b0;
    logic                             aresetn;
    logic                             cfg_wr_en;
    logic                             cfg_wr_data;
    logic                             s_tvalid;
    logic                             s_tready;
    logic [stbs_pkg::S_TDATA_W-1:0]   s_tdata;
    logic                             s_tuser;
    logic                             m_tvalid;
    logic                             m_tready;
    logic [stbs_pkg::M_TDATA_W-1:0]   m_tdata;
    logic [1:0]                       m_tuser;

    logic [stbs_pkg::KEY_W-1:0]       key_tbl [stbs_pkg::DEPTH];
    logic [stbs_pkg::VALUE_W-1:0]     val_tbl [stbs_pkg::DEPTH];
    int                               fill_count;
    logic [stbs_pkg::CNT_W-1:0]       search_sum;
    logic [stbs_pkg::CNT_W-1:0]       cost_sum;
    logic                             signed_mode;
    longint                           last_key;

    lookup_reply_t                    awaited_replies[$];
    int                               mismatch_count;
    int                               cycle_count;
    int                               send_idle_pct;
    int                               recv_stall_pct;

    sorted_table_binary_search u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic stbs_pkg::rel_t key_order(input logic [stbs_pkg::KEY_W-1:0] entry,
                                                 input logic [stbs_pkg::KEY_W-1:0] key);
        logic [stbs_pkg::KEY_W-1:0] e;
        logic [stbs_pkg::KEY_W-1:0] k;
        e = signed_mode ? {~entry[stbs_pkg::KEY_W-1], entry[stbs_pkg::KEY_W-2:0]} : entry;
        k = signed_mode ? {~key[stbs_pkg::KEY_W-1], key[stbs_pkg::KEY_W-2:0]} : key;
        if (e == k) return stbs_pkg::REL_EQ;
        return (e > k) ? stbs_pkg::REL_GT : stbs_pkg::REL_LT;
    endfunction

    function automatic lookup_reply_t predict_lookup(
            input logic func,
            input logic [stbs_pkg::KEY_W-1:0] key,
            input logic [stbs_pkg::VALUE_W-1:0] value);
        lookup_reply_t r;
        int lo;
        int hi;
        int mid;
        r = '0;
        if (func == stbs_pkg::FUNC_LOAD) begin
            if (fill_count < stbs_pkg::DEPTH) begin
                key_tbl[stbs_pkg::ADDR_W'(fill_count)] = key;
                val_tbl[stbs_pkg::ADDR_W'(fill_count)] = value;
                fill_count++;
            end else begin
                r.full_err = 1'b1;
            end
        end else begin
            lo = 0;
            hi = fill_count - 1;
            search_sum++;
            while (!r.found && lo <= hi) begin
                mid = (lo + hi) / 2;
                case (key_order(key_tbl[stbs_pkg::ADDR_W'(mid)], key))
                    stbs_pkg::REL_EQ: begin
                        cost_sum += stbs_pkg::CNT_W'(stbs_pkg::COST_EQ);
                        r.found = 1'b1;
                        r.value = val_tbl[stbs_pkg::ADDR_W'(mid)];
                    end
                    stbs_pkg::REL_GT: begin
                        cost_sum += stbs_pkg::CNT_W'(stbs_pkg::COST_GT);
                        hi = mid - 1;
                    end
                    default: begin
                        cost_sum += stbs_pkg::CNT_W'(stbs_pkg::COST_LT);
                        lo = mid + 1;
                    end
                endcase
            end
        end
        r.fill = stbs_pkg::COUNT_W'(fill_count);
        r.searches = search_sum;
        r.cost = cost_sum;
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h, expected %h", field, got, want);
        mismatch_count++;
    endtask

    always @(posedge aclk) begin : check_replies
        lookup_reply_t got;
        lookup_reply_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.found = m_tuser[0];
            got.full_err = m_tuser[1];
            got.value = m_tdata[stbs_pkg::VALUE_W-1:0];
            got.fill = m_tdata[stbs_pkg::VALUE_W +: stbs_pkg::COUNT_W];
            got.searches = m_tdata[stbs_pkg::VALUE_W + stbs_pkg::COUNT_W +: stbs_pkg::CNT_W];
            got.cost = m_tdata[stbs_pkg::VALUE_W + stbs_pkg::COUNT_W + stbs_pkg::CNT_W +:
                               stbs_pkg::CNT_W];
            if (awaited_replies.size() == 0) begin
                report_mismatch("unexpected beat", got.value, '0);
            end else begin
                want = awaited_replies.pop_front();
                if (got.found !== want.found)
                    report_mismatch("found", 32'(got.found), 32'(want.found));
                if (got.value !== want.value)
                    report_mismatch("found_value", got.value, want.value);
                if (got.fill !== want.fill)
                    report_mismatch("fill_level", 32'(got.fill), 32'(want.fill));
                if (got.full_err !== want.full_err)
                    report_mismatch("table_full_error", 32'(got.full_err),
                                    32'(want.full_err));
                if (got.searches !== want.searches)
                    report_mismatch("search_total", got.searches, want.searches);
                if (got.cost !== want.cost)
                    report_mismatch("compare_cost_total", got.cost, want.cost);
            end
        end
    end

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic send_beat(input logic func, input logic [stbs_pkg::KEY_W-1:0] key,
                             input logic [stbs_pkg::VALUE_W-1:0] value);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= func;
        s_tdata <= {value, key};
        do @(posedge aclk); while (!s_tready);
        awaited_replies.push_back(predict_lookup(func, key, value));
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (awaited_replies.size() != 0) @(posedge aclk);
    endtask

    task automatic set_compare_mode(input logic mode);
        wait_drained();
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= mode;
        signed_mode = mode;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [stbs_pkg::KEY_W-1:0] next_load_key();
        longint step;
        if ($urandom_range(99) < 2) return $urandom;
        step = $urandom_range(32'h007F_FFFF, 1);
        last_key = (last_key + step > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : last_key + step;
        return last_key[stbs_pkg::KEY_W-1:0];
    endfunction

    function automatic logic [stbs_pkg::KEY_W-1:0] pick_search_key();
        int r;
        logic [stbs_pkg::KEY_W-1:0] k;
        r = $urandom_range(99);
        if (fill_count == 0 || r >= 75) return $urandom;
        k = key_tbl[stbs_pkg::ADDR_W'($urandom_range(fill_count - 1))];
        if (r >= 55) k = $urandom_range(1) ? k + 1'b1 : k - 1'b1;
        return k;
    endfunction

    task automatic run_random_items(input int n_items, input int load_pct);
        for (int i = 0; i < n_items; i++) begin
            if ($urandom_range(99) < load_pct)
                send_beat(stbs_pkg::FUNC_LOAD, next_load_key(), $urandom);
            else
                send_beat(stbs_pkg::FUNC_SEARCH, pick_search_key(), $urandom);
        end
    endtask

    task automatic test_directed_cases();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        set_compare_mode(1'b0);
        send_beat(stbs_pkg::FUNC_SEARCH, 32'h0000_0000, 32'hFFFF_FFFF);
        send_beat(stbs_pkg::FUNC_LOAD, 32'h0000_0000, 32'hFFFF_FFFF);
        send_beat(stbs_pkg::FUNC_LOAD, 32'h0000_0010, 32'h0000_0000);
        send_beat(stbs_pkg::FUNC_LOAD, 32'h0000_0010, 32'h1234_5678);
        send_beat(stbs_pkg::FUNC_LOAD, 32'h0000_0020, 32'hA5A5_A5A5);
        send_beat(stbs_pkg::FUNC_LOAD, 32'h0000_0018, 32'h5A5A_5A5A);
        send_beat(stbs_pkg::FUNC_SEARCH, 32'h0000_0000, 32'h0000_0000);
        send_beat(stbs_pkg::FUNC_SEARCH, 32'h0000_0010, 32'hFFFF_FFFF);
        send_beat(stbs_pkg::FUNC_SEARCH, 32'h0000_0018, 32'h0000_0000);
        send_beat(stbs_pkg::FUNC_SEARCH, 32'h0000_0020, 32'h0000_0000);
        send_beat(stbs_pkg::FUNC_SEARCH, 32'h0000_0015, 32'h0000_0000);
        send_beat(stbs_pkg::FUNC_SEARCH, 32'hFFFF_FFFF, 32'h0000_0000);
        send_beat(stbs_pkg::FUNC_SEARCH, 32'h8000_0000, 32'h0000_0000);
        last_key = 64'h20;
    endtask

    task automatic test_signed_extremes();
        set_compare_mode(1'b1);
        send_beat(stbs_pkg::FUNC_SEARCH, 32'hFFFF_FFFF, 32'h0000_0000);
        send_beat(stbs_pkg::FUNC_SEARCH, 32'h8000_0000, 32'h0000_0000);
        send_beat(stbs_pkg::FUNC_SEARCH, 32'h7FFF_FFFF, 32'h0000_0000);
        send_beat(stbs_pkg::FUNC_SEARCH, 32'h0000_0020, 32'h0000_0000);
    endtask

    task automatic test_unsigned_stream();
        set_compare_mode(1'b0);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        run_random_items(220, 85);
    endtask

    task automatic test_signed_sender_gaps();
        set_compare_mode(1'b1);
        send_idle_pct = 77;
        recv_stall_pct = 0;
        run_random_items(220, 85);
    endtask

    task automatic test_unsigned_backpressure();
        set_compare_mode(1'b0);
        send_idle_pct = 0;
        recv_stall_pct = 77;
        run_random_items(220, 85);
    endtask

    task automatic test_signed_wrapped_keys();
        set_compare_mode(1'b1);
        send_idle_pct = 17;
        recv_stall_pct = 17;
        run_random_items(220, 85);
    endtask

    task automatic test_table_full();
        set_compare_mode(1'b0);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        while (fill_count < stbs_pkg::DEPTH) begin
            if ($urandom_range(99) < 5)
                send_beat(stbs_pkg::FUNC_SEARCH, pick_search_key(), $urandom);
            else
                send_beat(stbs_pkg::FUNC_LOAD, next_load_key(), $urandom);
        end
        for (int i = 0; i < 12; i++) begin
            send_beat(stbs_pkg::FUNC_LOAD, $urandom, $urandom);
            send_beat(stbs_pkg::FUNC_SEARCH, pick_search_key(), $urandom);
        end
        run_random_items(30, 0);
    endtask

    initial begin
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = stbs_pkg::FUNC_LOAD;
        fill_count = 0;
        search_sum = '0;
        cost_sum = '0;
        signed_mode = 1'b0;
        last_key = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_directed_cases();
        test_signed_extremes();
        test_unsigned_stream();
        test_signed_sender_gaps();
        test_unsigned_backpressure();
        test_signed_wrapped_keys();
        test_table_full();

        wait_drained();
        repeat (20) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
